[hw/rtl/bspq_pkg.sv]
package bspq_pkg;

  localparam int CAP_WIDTH   = 5;
  localparam int COUNT_WIDTH = 5;
  localparam int STAT_WIDTH  = 2;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STAT_WIDTH-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cmd_t;

endpackage

[hw/rtl/bspq_ifs.sv]
interface bspq_req_if #(
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
);
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [VALUE_WIDTH-1:0]           item_value;
  logic signed [PRIORITY_WIDTH-1:0] item_priority;

  modport source (output valid, op, item_value, item_priority, input ready);
  modport sink   (input valid, op, item_value, item_priority, output ready);
endinterface

interface bspq_rsp_if #(
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
);
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic                             head_valid;
  logic [VALUE_WIDTH-1:0]           head_value;
  logic signed [PRIORITY_WIDTH-1:0] head_priority;
  logic                             is_empty;
  logic                             is_full;
  logic [4:0]                       entry_count;

  modport source (output valid, status, head_valid, head_value, head_priority,
                  is_empty, is_full, entry_count, input ready);
  modport sink   (input valid, status, head_valid, head_value, head_priority,
                  is_empty, is_full, entry_count, output ready);
endinterface

[hw/rtl/bspq_cell.sv]
module bspq_cell #(
  parameter int VW = 32,
  parameter int PW = 16
) (
  input  logic                 clk,
  input  bspq_pkg::cmd_t       cmd,
  input  logic [VW-1:0]        new_value,
  input  logic signed [PW-1:0] new_prio,
  input  logic                 occ,
  input  logic                 prev_keep,
  input  logic [VW-1:0]        prev_value,
  input  logic signed [PW-1:0] prev_prio,
  input  logic [VW-1:0]        next_value,
  input  logic signed [PW-1:0] next_prio,
  output logic                 keep,
  output logic [VW-1:0]        value,
  output logic signed [PW-1:0] prio
);

  logic [VW-1:0]        value_next;
  logic signed [PW-1:0] prio_next;

  // entries at or above the new priority stay put
  assign keep = occ && (prio >= new_prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    priority if (cmd.pop) begin
      value_next = next_value;
      prio_next  = next_prio;
    end else if (cmd.push && !keep) begin
      if (prev_keep) begin
        value_next = new_value;
        prio_next  = new_prio;
      end else begin
        value_next = prev_value;
        prio_next  = prev_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

[hw/rtl/bounded_sorted_priority_queue.sv]
// Bounded priority queue, sorted by insertion into a chain of cells.
// req channel: one beat per operation (op 0 enqueue item_value with
// item_priority, op 1 dequeue the head). rsp channel: one beat per req
// beat, in order, giving status and the queue state after the operation
// (head value and priority, empty, full, entry count).
// Every cell compares the new priority with its own in parallel and
// either holds, loads the new entry, or takes its neighbor's entry. The
// rsp beat is valid in the cycle after the req beat is accepted; one
// operation per cycle is sustained while rsp is taken.
// A rsp beat sits in the output register until taken; req.ready stays low
// while it waits, which also freezes the cells.
// cfg_we/cfg_data write the capacity (values above DEPTH act as DEPTH,
// zero means always full). Write it only while the queue is idle.
// Reset (synchronous, rst high) empties the queue, sets capacity to 16
// and drops any pending rsp beat; no clearing pass is needed.
module bounded_sorted_priority_queue #(
  parameter int DEPTH          = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bspq_pkg::CAP_WIDTH-1:0]      cfg_data,
  bspq_req_if.sink                            req,
  bspq_rsp_if.source                          rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [bspq_pkg::CAP_WIDTH-1:0] capacity;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  logic                           rsp_valid;
  bspq_pkg::status_t              status;
  bspq_pkg::status_t              status_next;
  logic                           fire;
  logic                           full;
  bspq_pkg::cmd_t                 cmd;

  logic [VALUE_WIDTH-1:0]           val  [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] pri  [DEPTH];
  logic                             keep [DEPTH];

  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  assign full = (32'(count) >= 32'(capacity)) || (32'(count) >= 32'(DEPTH));

  always_comb begin
    cmd         = '0;
    count_next  = count;
    status_next = bspq_pkg::ST_DONE;
    if (fire) begin
      unique case (bspq_pkg::op_t'(req.op))
        bspq_pkg::OP_ENQ: begin
          if (full) begin
            status_next = bspq_pkg::ST_OVERFLOW;
          end else begin
            cmd.push   = 1'b1;
            count_next = count + CW'(1);
          end
        end
        bspq_pkg::OP_DEQ: begin
          if (count == '0) begin
            status_next = bspq_pkg::ST_UNDERFLOW;
          end else begin
            cmd.pop    = 1'b1;
            count_next = count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             prev_keep;
    logic [VALUE_WIDTH-1:0]           prev_value;
    logic signed [PRIORITY_WIDTH-1:0] prev_prio;
    logic [VALUE_WIDTH-1:0]           next_value;
    logic signed [PRIORITY_WIDTH-1:0] next_prio;

    if (i == 0) begin : g_first
      assign prev_keep  = 1'b1;
      assign prev_value = '0;
      assign prev_prio  = '0;
    end else begin : g_mid
      assign prev_keep  = keep[i-1];
      assign prev_value = val[i-1];
      assign prev_prio  = pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_value = '0;
      assign next_prio  = '0;
    end else begin : g_inner
      assign next_value = val[i+1];
      assign next_prio  = pri[i+1];
    end

    bspq_cell #(
      .VW (VALUE_WIDTH),
      .PW (PRIORITY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_value  (req.item_value),
      .new_prio   (req.item_priority),
      .occ        (CW'(i) < count),
      .prev_keep  (prev_keep),
      .prev_value (prev_value),
      .prev_prio  (prev_prio),
      .next_value (next_value),
      .next_prio  (next_prio),
      .keep       (keep[i]),
      .value      (val[i]),
      .prio       (pri[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= bspq_pkg::CAP_RESET;
      count     <= '0;
      rsp_valid <= 1'b0;
      status    <= bspq_pkg::ST_DONE;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (fire) begin
        count     <= count_next;
        status    <= status_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // state is frozen while a rsp beat waits, so fields read the live queue
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = status;
  assign rsp.head_valid    = (count != '0);
  assign rsp.head_value    = (count != '0) ? val[0] : '0;
  assign rsp.head_priority = (count != '0) ? pri[0] : '0;
  assign rsp.is_empty      = (count == '0);
  assign rsp.is_full       = full;
  assign rsp.entry_count   = bspq_pkg::COUNT_WIDTH'(count);

endmodule

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;
  localparam int VW     = 32;
  localparam int PW     = 16;
  localparam int BURSTY = -1;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    bspq_pkg::status_t                status;
    logic                             head_valid;
    logic [VW-1:0]                    head_value;
    logic signed [PW-1:0]             head_priority;
    logic                             is_empty;
    logic                             is_full;
    logic [bspq_pkg::COUNT_WIDTH-1:0] entry_count;
  } queue_snapshot_t;

  typedef struct packed {
    bspq_pkg::op_t        op;
    logic [VW-1:0]        value;
    logic signed [PW-1:0] prio;
    logic                 typed;
    queue_snapshot_t      want;
  } directed_row_t;

  typedef struct packed {
    int         cap;
    int         items;
    idle_mode_t mode;
    int         enq_pct;
  } phase_t;

  localparam queue_snapshot_t EMPTY_DONE =
    '{bspq_pkg::ST_DONE, 1'b0, 32'h0, 16'sh0, 1'b1, 1'b0, 5'd0};
  localparam queue_snapshot_t EMPTY_UNDER =
    '{bspq_pkg::ST_UNDERFLOW, 1'b0, 32'h0, 16'sh0, 1'b1, 1'b0, 5'd0};
  localparam queue_snapshot_t NO_SNAP =
    '{bspq_pkg::ST_DONE, 1'b0, 32'h0, 16'sh0, 1'b0, 1'b0, 5'd0};

  localparam int NUM_ROWS = 20;
  localparam directed_row_t DIR_ROWS [NUM_ROWS] = '{
    '{bspq_pkg::OP_DEQ, 32'h0,        16'sh0,    1'b1, EMPTY_UNDER},
    '{bspq_pkg::OP_ENQ, 32'hFFFFFFFF, 16'sh7FFF, 1'b1,
      '{bspq_pkg::ST_DONE, 1'b1, 32'hFFFFFFFF, 16'sh7FFF, 1'b0, 1'b0, 5'd1}},
    '{bspq_pkg::OP_ENQ, 32'h0,        16'sh8000, 1'b1,
      '{bspq_pkg::ST_DONE, 1'b1, 32'hFFFFFFFF, 16'sh7FFF, 1'b0, 1'b0, 5'd2}},
    '{bspq_pkg::OP_ENQ, 32'h1,        16'sh7FFF, 1'b1,
      '{bspq_pkg::ST_DONE, 1'b1, 32'hFFFFFFFF, 16'sh7FFF, 1'b0, 1'b0, 5'd3}},
    '{bspq_pkg::OP_ENQ, 32'h2,        16'sh0,    1'b0, NO_SNAP},
    '{bspq_pkg::OP_ENQ, 32'h3,        16'shFFFF, 1'b0, NO_SNAP},
    '{bspq_pkg::OP_ENQ, 32'h4,        16'sh0,    1'b0, NO_SNAP},
    '{bspq_pkg::OP_ENQ, 32'h5,        16'sh8000, 1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'hFFFFFFFF, 16'shFFFF, 1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'h0,        16'sh7FFF, 1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'h12345678, 16'sh8000, 1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'h0,        16'sh0,    1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'h0,        16'sh0,    1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'h0,        16'sh0,    1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'hFFFFFFFF, 16'sh7FFF, 1'b1, EMPTY_DONE},
    '{bspq_pkg::OP_DEQ, 32'hFFFFFFFF, 16'shFFFF, 1'b1, EMPTY_UNDER},
    '{bspq_pkg::OP_ENQ, 32'hA5A5A5A5, 16'sh8000, 1'b1,
      '{bspq_pkg::ST_DONE, 1'b1, 32'hA5A5A5A5, 16'sh8000, 1'b0, 1'b0, 5'd1}},
    '{bspq_pkg::OP_ENQ, 32'h5A5A5A5A, 16'sh0001, 1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'h0,        16'sh0,    1'b0, NO_SNAP},
    '{bspq_pkg::OP_DEQ, 32'h0,        16'sh0,    1'b1, EMPTY_DONE}
  };

  localparam int NUM_PHASES = 10;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{16, 300, IDLE_NONE, BURSTY},
    '{1,  120, IDLE_SEND, 50},
    '{31, 300, IDLE_RECV, BURSTY},
    '{0,  80,  IDLE_BOTH, 60},
    '{5,  200, IDLE_NONE, BURSTY},
    '{16, 14,  IDLE_BOTH, 100},
    '{3,  150, IDLE_RECV, 40},   // capacity now below the stored count
    '{17, 250, IDLE_SEND, BURSTY},
    '{2,  150, IDLE_BOTH, 50},
    '{16, 300, IDLE_BOTH, BURSTY}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [bspq_pkg::CAP_WIDTH-1:0] cfg_data;
  logic sink_ready = 1'b0;
  idle_mode_t idle_mode = IDLE_NONE;

  logic            typed_beat;
  queue_snapshot_t typed_want;

  bspq_req_if #(.VALUE_WIDTH(VW), .PRIORITY_WIDTH(PW)) req_ch ();
  bspq_rsp_if #(.VALUE_WIDTH(VW), .PRIORITY_WIDTH(PW)) rsp_ch ();

  assign rsp_ch.ready = sink_ready;

  bounded_sorted_priority_queue #(
    .DEPTH(QDEPTH),
    .VALUE_WIDTH(VW),
    .PRIORITY_WIDTH(PW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the queue contents
  logic [VW-1:0]                  shadow_value [QDEPTH];
  logic signed [PW-1:0]           shadow_prio  [QDEPTH];
  int                             shadow_count;
  logic [bspq_pkg::CAP_WIDTH-1:0] shadow_cap;

  queue_snapshot_t pending_snaps [$];
  int mismatches;
  int n_enq, n_deq, n_ovf, n_udf, peak_count;

  function automatic queue_snapshot_t apply_op(bspq_pkg::op_t op, logic [VW-1:0] value,
                                               logic signed [PW-1:0] prio);
    queue_snapshot_t s;
    int lim;
    int pos;
    int i;
    lim = (shadow_cap > QDEPTH) ? QDEPTH : int'(shadow_cap);
    s.status = bspq_pkg::ST_DONE;
    if (op == bspq_pkg::OP_ENQ) begin
      if (shadow_count >= lim) begin
        s.status = bspq_pkg::ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[pos] = value;
        shadow_prio[pos]  = prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        s.status = bspq_pkg::ST_UNDERFLOW;
      end else begin
        for (i = 1; i < shadow_count; i++) begin
          shadow_value[i-1] = shadow_value[i];
          shadow_prio[i-1]  = shadow_prio[i];
        end
        shadow_count--;
      end
    end
    s.head_valid    = (shadow_count > 0);
    s.head_value    = (shadow_count > 0) ? shadow_value[0] : '0;
    s.head_priority = (shadow_count > 0) ? shadow_prio[0] : '0;
    s.is_empty      = (shadow_count == 0);
    s.is_full       = (shadow_count >= lim);
    s.entry_count   = shadow_count[bspq_pkg::COUNT_WIDTH-1:0];
    return s;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    queue_snapshot_t pred;
    queue_snapshot_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        pred = apply_op(bspq_pkg::op_t'(req_ch.op), req_ch.item_value,
                        req_ch.item_priority);
        if (req_ch.op == bspq_pkg::OP_ENQ) n_enq++;
        else n_deq++;
        if (pred.status == bspq_pkg::ST_OVERFLOW) n_ovf++;
        if (pred.status == bspq_pkg::ST_UNDERFLOW) n_udf++;
        if (shadow_count > peak_count) peak_count = shadow_count;
        pending_snaps.push_back(typed_beat ? typed_want : pred);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_snaps.size() == 0) begin
          report_mismatch("unexpected result beat", 32'd1, 32'd0);
        end else begin
          want = pending_snaps.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
          if (rsp_ch.head_valid !== want.head_valid)
            report_mismatch("head_valid", 32'(rsp_ch.head_valid), 32'(want.head_valid));
          if (rsp_ch.head_value !== want.head_value)
            report_mismatch("head_value", rsp_ch.head_value, want.head_value);
          if (rsp_ch.head_priority !== want.head_priority)
            report_mismatch("head_priority", 32'(unsigned'(rsp_ch.head_priority)),
                            32'(unsigned'(want.head_priority)));
          if (rsp_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(rsp_ch.is_empty), 32'(want.is_empty));
          if (rsp_ch.is_full !== want.is_full)
            report_mismatch("is_full", 32'(rsp_ch.is_full), 32'(want.is_full));
          if (rsp_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(rsp_ch.entry_count), 32'(want.entry_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECV: sink_ready <= ($urandom_range(99) >= 85);
        IDLE_BOTH: sink_ready <= ($urandom_range(99) >= 13);
        default:   sink_ready <= 1'b1;
      endcase
    end
  end

  task automatic send_beat(input bspq_pkg::op_t op, input logic [VW-1:0] value,
                           input logic signed [PW-1:0] prio, input logic typed,
                           input queue_snapshot_t want);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 85 : (idle_mode == IDLE_BOTH) ? 13 : 0;
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.item_value    <= value;
    req_ch.item_priority <= prio;
    typed_beat           <= typed;
    typed_want           <= want;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain_queue();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    phase_t ph;
    int pct;
    bspq_pkg::op_t op;
    logic [VW-1:0] value;
    logic signed [PW-1:0] prio;

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    req_ch.valid         = 1'b0;
    req_ch.op            = bspq_pkg::OP_ENQ;
    req_ch.item_value    = '0;
    req_ch.item_priority = '0;
    typed_beat           = 1'b0;
    typed_want           = NO_SNAP;
    shadow_count         = 0;
    shadow_cap           = bspq_pkg::CAP_RESET;
    mismatches           = 0;
    n_enq = 0; n_deq = 0; n_ovf = 0; n_udf = 0; peak_count = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_mode = IDLE_BOTH;
    for (int r = 0; r < NUM_ROWS; r++)
      send_beat(DIR_ROWS[r].op, DIR_ROWS[r].value, DIR_ROWS[r].prio,
                DIR_ROWS[r].typed, DIR_ROWS[r].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = PHASES[p];
      drain_queue();
      cfg_we   <= 1'b1;
      cfg_data <= ph.cap[bspq_pkg::CAP_WIDTH-1:0];
      @(posedge clk);
      cfg_we     <= 1'b0;
      shadow_cap  = ph.cap[bspq_pkg::CAP_WIDTH-1:0];
      idle_mode   = ph.mode;
      for (int k = 0; k < ph.items; k++) begin
        if (k == ph.items / 2) drain_queue();
        if (ph.enq_pct == BURSTY) pct = ((k / 24) % 2 == 0) ? 80 : 25;
        else pct = ph.enq_pct;
        op = ($urandom_range(99) < pct) ? bspq_pkg::OP_ENQ : bspq_pkg::OP_DEQ;
        case ($urandom_range(7))
          0:       value = '0;
          1:       value = '1;
          default: value = $urandom;
        endcase
        case ($urandom_range(4))
          0:       prio = PW'($urandom);
          1:       prio = PW'($signed($urandom_range(4)) - 2);
          2:       prio = PW'($signed($urandom_range(16)) - 8);
          3: begin
            case ($urandom_range(3))
              0:       prio = 16'sh7FFF;
              1:       prio = 16'sh8000;
              2:       prio = 16'sh0000;
              default: prio = 16'shFFFF;
            endcase
          end
          default: prio = PW'($signed($urandom_range(2)) - 1);
        endcase
        send_beat(op, value, prio, 1'b0, NO_SNAP);
      end
    end

    drain_queue();
    repeat (8) @(posedge clk);
    if (pending_snaps.size() != 0) begin
      report_mismatch("results outstanding", 32'(pending_snaps.size()), 32'd0);
    end
    $display("covered %0d enqueues and %0d dequeues, %0d overflows, %0d underflows",
             n_enq, n_deq, n_ovf, n_udf);
    $display("capacities 0 to 31 incl. lowered below count, peak depth %0d, %0d mismatches",
             peak_count, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bspq_pkg.sv
hw/rtl/bspq_ifs.sv
hw/rtl/bspq_cell.sv
hw/rtl/bounded_sorted_priority_queue.sv
bench/testbench.sv
